// ----- sv/tpr_pkg.sv -----
// Package for the tracker pattern repacker.
// Holds the cell and command types, sizes, phase and state enums and the cell builder.
// No dependencies.
package tpr_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 32;
  localparam int unsigned CMD_DEPTH        = 4;
  localparam int unsigned CH_W             = 5;
  localparam int unsigned CNT_W            = 6;
  localparam logic [CNT_W-1:0] CNT_RESET   = 6'd8;

  localparam logic [7:0] FLAG_BASE  = 8'h80;
  localparam logic [7:0] FLAG_NOTE  = 8'h03;
  localparam logic [7:0] FLAG_VOL   = 8'h04;
  localparam logic [7:0] FLAG_EFF   = 8'h18;
  localparam logic [6:0] NOTE_EMPTY = 7'd97;

  localparam int unsigned LEAD_CH_BIT_HI = 4;
  localparam int unsigned LEAD_NOTE_BIT  = 5;
  localparam int unsigned LEAD_VOL_BIT   = 6;
  localparam int unsigned LEAD_EFF_BIT   = 7;
  localparam int unsigned NOTE_XINS_BIT  = 7;

  typedef enum logic [2:0] {
    PH_LEAD, PH_NOTE, PH_INS, PH_INSHI, PH_VOL, PH_EFF, PH_PARAM
  } phase_t;

  typedef enum logic {
    BK_IDLE, BK_DRAIN
  } back_state_t;

  typedef struct packed {
    logic [7:0] flags;
    logic [6:0] note;
    logic [6:0] instrument;
    logic [7:0] volume;
    logic [7:0] effect;
    logic [7:0] param;
  } cell_t;

  typedef struct packed {
    logic             row_end;
    logic [CH_W-1:0]  channel;
    logic [CNT_W-1:0] count;
    cell_t            cell_data;
  } cmd_t;

  // Builds a stored cell from a finished entry. Unflagged fields are already zero.
  function automatic cell_t make_cell(input logic [7:0] lead, input logic [7:0] note,
                                      input logic [6:0] ins, input logic [7:0] vol,
                                      input logic [7:0] eff, input logic [7:0] param);
    cell_t c;
    c.flags      = FLAG_BASE;
    c.note       = '0;
    c.instrument = ins;
    c.volume     = vol;
    c.effect     = eff;
    c.param      = param;
    if (lead[LEAD_NOTE_BIT]) begin
      c.flags = c.flags | FLAG_NOTE;
      c.note  = note[6:0];
      if (c.note == 7'd0 || c.note > NOTE_EMPTY) begin
        c.note = NOTE_EMPTY;
      end
    end
    if (lead[LEAD_VOL_BIT]) begin
      c.flags = c.flags | FLAG_VOL;
    end
    if (lead[LEAD_EFF_BIT]) begin
      c.flags = c.flags | FLAG_EFF;
    end
    return c;
  endfunction

endpackage

// ----- sv/tpr_parser.sv -----
// Front end of the tracker pattern repacker: parses the packed byte stream.
// Emits store and row-end commands into the command queue. Depends on tpr_pkg.
module tpr_parser
  import tpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_valid,
  output logic             byte_ready,
  input  logic [7:0]       data_byte,
  input  logic [CNT_W-1:0] active_count,
  input  logic             queue_full,
  output logic             push,
  output cmd_t             push_cmd
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] lead_r, lead_nxt;
  logic [7:0] note_r, note_nxt;
  logic [6:0] ins_r, ins_nxt;
  logic [7:0] vol_r, vol_nxt;
  logic [7:0] eff_r, eff_nxt;
  logic       accept;
  logic       want_push;
  logic       lead6, lead7;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;
  assign lead6      = lead_r[LEAD_VOL_BIT];
  assign lead7      = lead_r[LEAD_EFF_BIT];

  // Next phase and pending data.
  always_comb begin
    phase_nxt = phase_r;
    lead_nxt  = lead_r;
    note_nxt  = note_r;
    ins_nxt   = ins_r;
    vol_nxt   = vol_r;
    eff_nxt   = eff_r;
    if (accept) begin
      case (phase_r)
        PH_LEAD: begin
          if (data_byte != 8'd0) begin
            lead_nxt = data_byte;
            note_nxt = '0;
            ins_nxt  = '0;
            vol_nxt  = '0;
            eff_nxt  = '0;
            if (data_byte[LEAD_NOTE_BIT]) begin
              phase_nxt = PH_NOTE;
            end else if (data_byte[LEAD_VOL_BIT]) begin
              phase_nxt = PH_VOL;
            end else if (data_byte[LEAD_EFF_BIT]) begin
              phase_nxt = PH_EFF;
            end
          end
        end
        PH_NOTE: begin
          note_nxt  = data_byte;
          phase_nxt = PH_INS;
        end
        PH_INS: begin
          ins_nxt = data_byte[6:0];
          if (note_r[NOTE_XINS_BIT]) begin
            phase_nxt = PH_INSHI;
          end else if (lead6) begin
            phase_nxt = PH_VOL;
          end else if (lead7) begin
            phase_nxt = PH_EFF;
          end else begin
            phase_nxt = PH_LEAD;
          end
        end
        PH_INSHI: begin
          if (lead6) begin
            phase_nxt = PH_VOL;
          end else if (lead7) begin
            phase_nxt = PH_EFF;
          end else begin
            phase_nxt = PH_LEAD;
          end
        end
        PH_VOL: begin
          vol_nxt   = data_byte;
          phase_nxt = lead7 ? PH_EFF : PH_LEAD;
        end
        PH_EFF: begin
          eff_nxt   = data_byte;
          phase_nxt = PH_PARAM;
        end
        PH_PARAM: begin
          phase_nxt = PH_LEAD;
        end
        default: begin
          phase_nxt = PH_LEAD;
        end
      endcase
    end
  end

  // Command output: a row end, or a finished entry.
  always_comb begin
    want_push          = 1'b0;
    push_cmd.row_end   = 1'b0;
    push_cmd.channel   = lead_r[LEAD_CH_BIT_HI:0];
    push_cmd.count     = active_count;
    push_cmd.cell_data = make_cell(lead_r, note_r, ins_r, vol_r, eff_r, 8'd0);
    case (phase_r)
      PH_LEAD: begin
        push_cmd.channel   = data_byte[LEAD_CH_BIT_HI:0];
        push_cmd.cell_data = make_cell(data_byte, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0);
        if (data_byte == 8'd0) begin
          want_push        = 1'b1;
          push_cmd.row_end = 1'b1;
        end else if (data_byte[7:5] == 3'd0) begin
          want_push = 1'b1;
        end
      end
      PH_INS: begin
        push_cmd.cell_data = make_cell(lead_r, note_r, data_byte[6:0], 8'd0, 8'd0, 8'd0);
        want_push          = !note_r[NOTE_XINS_BIT] && !lead6 && !lead7;
      end
      PH_INSHI: begin
        want_push = !lead6 && !lead7;
      end
      PH_VOL: begin
        push_cmd.cell_data = make_cell(lead_r, note_r, ins_r, data_byte, 8'd0, 8'd0);
        want_push          = !lead7;
      end
      PH_PARAM: begin
        push_cmd.cell_data = make_cell(lead_r, note_r, ins_r, vol_r, eff_r, data_byte);
        want_push          = 1'b1;
      end
      default: begin
        want_push = 1'b0;
      end
    endcase
    // Entries for channels outside the active range are parsed and dropped.
    if (!push_cmd.row_end && ({1'b0, push_cmd.channel} >= active_count)) begin
      want_push = 1'b0;
    end
  end

  assign push = accept && want_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      lead_r  <= '0;
      note_r  <= '0;
      ins_r   <= '0;
      vol_r   <= '0;
      eff_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      lead_r  <= lead_nxt;
      note_r  <= note_nxt;
      ins_r   <= ins_nxt;
      vol_r   <= vol_nxt;
      eff_r   <= eff_nxt;
    end
  end

endmodule

// ----- sv/tpr_cmd_fifo.sv -----
// Short command queue between the parser and the row store.
// Depends on tpr_pkg for the command type.
module tpr_cmd_fifo
  import tpr_pkg::*;
#(
  parameter int unsigned DEPTH = CMD_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  cmd_t              slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  assign full  = (fill_r == FILL_W'(DEPTH));
  assign empty = (fill_r == '0);
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ----- sv/tpr_row_drain.sv -----
// Back end of the tracker pattern repacker: row store and row drain.
// Executes queued commands and drives the registered result channel. Depends on tpr_pkg.
module tpr_row_drain
  import tpr_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_empty,
  input  cmd_t            cmd_head,
  output logic            cmd_pop,
  output logic            res_valid,
  input  logic            res_ready,
  output cell_t           res_cell,
  output logic [CH_W-1:0] res_channel,
  output logic            res_last
);

  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  back_state_t             state_r, state_nxt;
  cell_t                   cells_r [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] valid_r;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r;
  cell_t                   out_cell_r;
  logic [CH_W-1:0]         out_ch_r;
  logic                    out_last_r;
  logic                    out_free;
  logic                    is_last;
  logic                    store_en;
  logic                    load_en;
  logic                    clear_all;
  cell_t                   rd_cell;

  assign out_free = !out_valid_r || res_ready;
  assign is_last  = ((CNT_W'(idx_r) + 1'b1) == cnt_r);
  assign rd_cell  = valid_r[idx_r] ? cells_r[idx_r] : cell_t'({FLAG_BASE, 38'd0});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty && cmd_head.row_end && cmd_head.count != '0) begin
          state_nxt = BK_DRAIN;
          idx_nxt   = '0;
          cnt_nxt   = cmd_head.count;
        end
      end
      BK_DRAIN: begin
        if (out_free) begin
          if (is_last) begin
            state_nxt = BK_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    cmd_pop   = 1'b0;
    store_en  = 1'b0;
    load_en   = 1'b0;
    clear_all = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (!cmd_head.row_end) begin
            store_en = 1'b1;
          end else if (cmd_head.count == '0) begin
            clear_all = 1'b1;
          end
        end
      end
      BK_DRAIN: begin
        load_en   = out_free;
        clear_all = out_free && is_last;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      cells_r[cmd_head.channel[IDX_W-1:0]] <= cmd_head.cell_data;
    end
    if (load_en) begin
      out_cell_r <= rd_cell;
      out_ch_r   <= CH_W'(idx_r);
      out_last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      valid_r     <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      if (clear_all) begin
        valid_r <= '0;
      end else if (store_en) begin
        valid_r[cmd_head.channel[IDX_W-1:0]] <= 1'b1;
      end
      if (load_en) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign res_valid   = out_valid_r;
  assign res_cell    = out_cell_r;
  assign res_channel = out_ch_r;
  assign res_last    = out_last_r;

endmodule

// ----- sv/tracker_pattern_repacker.sv -----
// Top level of the tracker pattern repacker.
// Instantiates tpr_parser, tpr_cmd_fifo and tpr_row_drain; uses tpr_pkg.
//
// The block takes packed pattern data one byte per request and, at each zero
// lead byte, sends one cell per active channel in ascending channel order,
// with row_last set on the final cell. The parser takes one byte every clock
// cycle while the queue is not full and turns each finished entry or row end
// into a command for a four-deep queue. The row store takes one queued store
// per cycle while idle; a row end reads the store out at one cell per cycle,
// while the output is not stalled, into a registered output stage, and a row
// with no data bytes is bound by that drain. While the drain runs the parser
// keeps accepting bytes until the queue holds four commands. The store is
// cleared in the same cycle as the last cell of a row is read, so no clearing
// pass follows reset. The channel count register sits at byte address 0 of
// the APB port; entries for channels at or above the count in force when
// they complete are dropped.
module tracker_pattern_repacker
  import tpr_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_cell_flags,
  output logic [6:0]  out_note_value,
  output logic [6:0]  out_instrument_low,
  output logic [7:0]  out_volume_value,
  output logic [7:0]  out_effect_kind,
  output logic [7:0]  out_effect_param,
  output logic [4:0]  out_channel_index,
  output logic        out_row_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] active_count;
  logic             cfg_hit;
  logic             q_full, q_empty, q_push, q_pop;
  cmd_t             q_in, q_head;
  cell_t            res_cell;

  // Register 0 covers byte addresses 0 to 3; the upper half of the space holds nothing.
  assign cfg_hit = !paddr[2];
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? {{(32 - CNT_W){1'b0}}, count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_RESET;
    end else if (psel && penable && pwrite && cfg_hit) begin
      count_r <= pwdata[CNT_W-1:0];
    end
  end

  // A count above the store depth behaves as the store depth.
  assign active_count = (count_r > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : count_r;

  tpr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (in_valid),
    .byte_ready  (in_ready),
    .data_byte   (in_data_byte),
    .active_count(active_count),
    .queue_full  (q_full),
    .push        (q_push),
    .push_cmd    (q_in)
  );

  tpr_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_in),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  tpr_row_drain #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_drain (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (q_empty),
    .cmd_head   (q_head),
    .cmd_pop    (q_pop),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res_cell   (res_cell),
    .res_channel(out_channel_index),
    .res_last   (out_row_last)
  );

  assign out_cell_flags     = res_cell.flags;
  assign out_note_value     = res_cell.note;
  assign out_instrument_low = res_cell.instrument;
  assign out_volume_value   = res_cell.volume;
  assign out_effect_kind    = res_cell.effect;
  assign out_effect_param   = res_cell.param;

endmodule
